>>> rtl/avg_pool_2d_stream_unit_macros.svh
// assertion macros shared by the average pooling block
`ifndef AVG_POOL_2D_STREAM_UNIT_MACROS_SVH
`define AVG_POOL_2D_STREAM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define APOOL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("avg pool assertion failed");
`define APOOL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("avg pool reset assertion failed");
`else
`define APOOL_ASSERT(lbl, prop)
`define APOOL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/apool_pkg.sv
// shared types and constants of the average pooling block
`default_nettype none
package apool_pkg;
    localparam int CFG_BITS  = 11;
    localparam int DIM_BITS  = 13;
    localparam int KERN_BITS = 4;
    localparam int PAD_BITS  = 3;
    localparam int IDX_BITS  = 3;
    localparam int WS_BITS   = 18;
    localparam int SLOT_BITS = 3;
    localparam int KK_BITS   = 7;

    typedef enum logic [IDX_BITS-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_KERNEL     = 3'd4,
        REG_STEP       = 3'd5,
        REG_PADDING    = 3'd6
    } t_reg_idx;

    // clamped configuration as the sequencer sees it
    typedef struct packed {
        logic [DIM_BITS-1:0]  w;
        logic [DIM_BITS-1:0]  h;
        logic [DIM_BITS-1:0]  ow;
        logic [DIM_BITS-1:0]  oh;
        logic [KERN_BITS-1:0] k;
        logic [KERN_BITS-1:0] s;
        logic [PAD_BITS-1:0]  pad;
        logic [KK_BITS-1:0]   kk;
    } t_cfg;
endpackage
`default_nettype wire

>>> rtl/apool_ram.sv
// generic single-clock ram with registered read
`default_nettype none
module apool_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/apool_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module apool_div #(
    parameter int NB = 13,
    parameter int DB = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NB-1:0] i_numer,
    input  wire logic [DB-1:0] i_denom,
    output logic               o_done,
    output logic      [NB-1:0] o_quot
);
    localparam int CW = $clog2(NB + 1);

    logic [DB:0]   r_rem;
    logic [NB-1:0] r_quo;
    logic [DB-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DB:0]   trial;
    logic          fits;

    // shift in next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem[DB-1:0], r_quo[NB-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_numer;
                r_den  <= i_denom;
                r_cnt  <= CW'(NB);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
                r_quo <= {r_quo[NB-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

>>> rtl/apool_cfg.sv
// configuration registers with range clamping
`default_nettype none
module apool_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_KERNEL = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [apool_pkg::IDX_BITS-1:0] i_index,
    input  wire logic [apool_pkg::CFG_BITS-1:0] i_data,
    output apool_pkg::t_cfg                    o_cfg
);
    localparam int DB = apool_pkg::DIM_BITS;
    localparam int KB = apool_pkg::KERN_BITS;
    localparam logic [DB-1:0] LIM_W = DB'(MAX_WIDTH);
    localparam logic [DB-1:0] LIM_H = DB'(MAX_HEIGHT);
    localparam logic [KB-1:0] LIM_K = KB'(MAX_KERNEL);

    logic [apool_pkg::CFG_BITS-1:0]  r_in_w, r_in_h, r_out_w, r_out_h;
    logic [KB-1:0]                   r_kern, r_step;
    logic [apool_pkg::PAD_BITS-1:0]  r_pad;
    logic [DB-1:0]                   ext_w, ext_h, ext_ow, ext_oh;
    logic [KB-1:0]                   k_c;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_w  <= apool_pkg::CFG_BITS'(1);
            r_in_h  <= apool_pkg::CFG_BITS'(1);
            r_out_w <= apool_pkg::CFG_BITS'(1);
            r_out_h <= apool_pkg::CFG_BITS'(1);
            r_kern  <= KB'(2);
            r_step  <= KB'(2);
            r_pad   <= '0;
        end else if (i_wr) begin
            case (apool_pkg::t_reg_idx'(i_index))
                apool_pkg::REG_IN_WIDTH:   r_in_w  <= i_data;
                apool_pkg::REG_IN_HEIGHT:  r_in_h  <= i_data;
                apool_pkg::REG_OUT_WIDTH:  r_out_w <= i_data;
                apool_pkg::REG_OUT_HEIGHT: r_out_h <= i_data;
                apool_pkg::REG_KERNEL:     r_kern  <= i_data[KB-1:0];
                apool_pkg::REG_STEP:       r_step  <= i_data[KB-1:0];
                apool_pkg::REG_PADDING:    r_pad   <= i_data[apool_pkg::PAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the supported range
    always_comb begin
        ext_w  = DB'(r_in_w);
        ext_h  = DB'(r_in_h);
        ext_ow = DB'(r_out_w);
        ext_oh = DB'(r_out_h);
        o_cfg.w  = (ext_w == '0) ? DB'(1) : ((ext_w > LIM_W) ? LIM_W : ext_w);
        o_cfg.h  = (ext_h == '0) ? DB'(1) : ((ext_h > LIM_H) ? LIM_H : ext_h);
        o_cfg.ow = (ext_ow == '0) ? DB'(1) : ((ext_ow > LIM_W) ? LIM_W : ext_ow);
        o_cfg.oh = (ext_oh == '0) ? DB'(1) : ((ext_oh > LIM_H) ? LIM_H : ext_oh);
        k_c      = (r_kern == '0) ? KB'(1) : ((r_kern > LIM_K) ? LIM_K : r_kern);
        o_cfg.k  = k_c;
        o_cfg.s  = (r_step == '0) ? KB'(1) : r_step;
        o_cfg.pad = r_pad;
        o_cfg.kk = apool_pkg::KK_BITS'(k_c * k_c);
    end
endmodule
`default_nettype wire

>>> rtl/avg_pool_2d_stream_unit.sv
// top level: window sequencer around the accumulator ram
//
//  channel  direction  signals                                   payload
//  in       sink       i_in_valid / o_in_ready                   i_sample
//  out      source     o_out_valid / i_out_ready                 o_average, o_out_row,
//                                                                o_out_col, o_frame_done
//  cfg      sink       i_cfg_valid / o_cfg_ready (always high)   i_cfg_index, i_cfg_data
//
// one sample at a time: an accept step, four serial range divisions, a
// setup step, then per touched window a skip or a ram read-modify-write,
// plus a serial averaging division and an output step per emitted window,
// and a final step to advance the counters.
// the serial dividers and the single ram port set this pace.
// reset is synchronous; no clearing pass, ram entries are written before their value is used.
// a full output register stalls the sequencer in its output step.
`default_nettype none
`include "avg_pool_2d_stream_unit_macros.svh"
module avg_pool_2d_stream_unit #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_average,
    output logic [$clog2(MAX_HEIGHT)-1:0]          o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_out_col,
    output logic                                   o_frame_done,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [apool_pkg::IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [apool_pkg::CFG_BITS-1:0]    i_cfg_data
);
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int RB  = $clog2(MAX_HEIGHT);
    localparam int SB  = SAMPLE_BITS;
    localparam int AB  = SAMPLE_BITS + 6;
    localparam int DB  = apool_pkg::DIM_BITS;
    localparam int WB  = apool_pkg::WS_BITS;
    localparam int SLB = apool_pkg::SLOT_BITS;
    localparam int MB  = SLB + CB;
    localparam logic [AB-1:0] POS_LIM = AB'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [AB-1:0] NEG_LIM = AB'(64'd1 << (SB - 1));

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_SETUP, S_WIN, S_RMW,
        S_AVG_GO, S_AVG_WAIT, S_OUT, S_ADV
    } t_state;

    apool_pkg::t_cfg cfg;
    t_state          r_state;

    logic [RB-1:0]        r_row;
    logic [CB-1:0]        r_col;
    logic signed [SB-1:0] r_x;
    logic [DB-1:0]        r_pr, r_pc;
    logic [1:0]           r_job;
    logic [DB-1:0]        r_q [4];
    logic [RB-1:0]        r_orow, r_or_hi;
    logic [CB-1:0]        r_ocol, r_oc_lo, r_oc_hi;
    logic                 r_first, r_emit;
    logic [AB-1:0]        r_acc;
    logic [SB-1:0]        r_avg;
    logic                 r_out_valid;
    logic [SB-1:0]        r_out_avg;
    logic [RB-1:0]        r_out_row;
    logic [CB-1:0]        r_out_col;
    logic                 r_out_last;

    // configuration port
    apool_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_KERNEL(MAX_KERNEL)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_cfg_valid),
        .i_index(i_cfg_index),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );
    assign o_cfg_ready = 1'b1;

    // window range division: numerators for the four bounds
    logic [DB-1:0] idx_numer, idx_quot;
    logic          idx_start, idx_done;
    logic [DB-1:0] s_ext, k_ext;
    always_comb begin
        s_ext = DB'(cfg.s);
        k_ext = DB'(cfg.k);
        case (r_job)
            2'd0:    idx_numer = r_pr;
            2'd1:    idx_numer = r_pr + s_ext - k_ext;
            2'd2:    idx_numer = r_pc;
            default: idx_numer = r_pc + s_ext - k_ext;
        endcase
        idx_start = (r_state == S_DIV_GO);
    end

    apool_div #(.NB(DB), .DB(apool_pkg::KERN_BITS)) u_idx_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(idx_start),
        .i_numer(idx_numer),
        .i_denom(cfg.s),
        .o_done (idx_done),
        .o_quot (idx_quot)
    );

    // bounds of the windows this sample touches
    logic [DB-1:0] or_hi_f, or_lo_f, oc_hi_f, oc_lo_f, oh_m1, ow_m1;
    always_comb begin
        oh_m1   = cfg.oh - 1'b1;
        ow_m1   = cfg.ow - 1'b1;
        or_hi_f = (r_q[0] > oh_m1) ? oh_m1 : r_q[0];
        oc_hi_f = (r_q[2] > ow_m1) ? ow_m1 : r_q[2];
        or_lo_f = (r_pr + 1'b1 >= k_ext) ? r_q[1] : '0;
        oc_lo_f = (r_pc + 1'b1 >= k_ext) ? r_q[3] : '0;
    end

    // in-image extent of the current window
    logic signed [WB-1:0] ws, wc, rlo, rhi, clo, chi, r_s, c_s, h_m1, w_m1;
    logic                 skip, first, emit;
    always_comb begin
        ws   = $signed(WB'(r_orow) * WB'(cfg.s)) - $signed(WB'(cfg.pad));
        wc   = $signed(WB'(r_ocol) * WB'(cfg.s)) - $signed(WB'(cfg.pad));
        h_m1 = $signed(WB'(cfg.h)) - WB'(1);
        w_m1 = $signed(WB'(cfg.w)) - WB'(1);
        r_s  = $signed(WB'(r_row));
        c_s  = $signed(WB'(r_col));
        rlo  = (ws < 0) ? '0 : ws;
        clo  = (wc < 0) ? '0 : wc;
        rhi  = ws + $signed(WB'(cfg.k)) - WB'(1);
        chi  = wc + $signed(WB'(cfg.k)) - WB'(1);
        if (rhi > h_m1) rhi = h_m1;
        if (chi > w_m1) chi = w_m1;
        skip  = (c_s > chi) || (r_s > rhi);
        first = (r_s == rlo) && (c_s == clo);
        emit  = (r_s == rhi) && (c_s == chi);
    end

    // accumulator ram read-modify-write
    logic [MB-1:0] ram_addr;
    logic          ram_re, ram_we;
    logic [AB-1:0] ram_rdata, x_ext, acc_new;
    always_comb begin
        ram_addr = {r_orow[SLB-1:0], r_ocol};
        ram_re   = (r_state == S_WIN) && !skip;
        ram_we   = (r_state == S_RMW);
        x_ext    = AB'(r_x);
        acc_new  = r_first ? x_ext : (ram_rdata + x_ext);
    end

    apool_ram #(.WIDTH(AB), .DEPTH(1 << MB)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_addr),
        .i_wdata(acc_new),
        .i_re   (ram_re),
        .i_raddr(ram_addr),
        .o_rdata(ram_rdata)
    );

    // averaging division on the magnitude, sign and saturation after
    logic [AB-1:0] acc_mag, avg_quot;
    logic          avg_start, avg_done;
    logic [SB-1:0] avg_sat;
    always_comb begin
        acc_mag   = r_acc[AB-1] ? (~r_acc + 1'b1) : r_acc;
        avg_start = (r_state == S_AVG_GO);
        if (r_acc[AB-1]) begin
            avg_sat = (avg_quot > NEG_LIM) ? SB'(NEG_LIM) : SB'(~avg_quot + 1'b1);
        end else begin
            avg_sat = (avg_quot > POS_LIM) ? SB'(POS_LIM) : SB'(avg_quot);
        end
    end

    apool_div #(.NB(AB), .DB(apool_pkg::KK_BITS)) u_avg_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(avg_start),
        .i_numer(acc_mag),
        .i_denom(cfg.kk),
        .o_done (avg_done),
        .o_quot (avg_quot)
    );

    // next window in row-major order
    logic          last_win;
    logic [RB-1:0] n_orow;
    logic [CB-1:0] n_ocol;
    always_comb begin
        last_win = (r_ocol == r_oc_hi) && (r_orow == r_or_hi);
        if (r_ocol == r_oc_hi) begin
            n_ocol = r_oc_lo;
            n_orow = r_orow + 1'b1;
        end else begin
            n_ocol = r_ocol + 1'b1;
            n_orow = r_orow;
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_job       <= '0;
        end else begin
            // the output step reloads the beat itself
            if (i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample;
                        r_pr    <= DB'(r_row) + DB'(cfg.pad);
                        r_pc    <= DB'(r_col) + DB'(cfg.pad);
                        r_job   <= '0;
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (idx_done) begin
                        r_q[r_job] <= idx_quot;
                        if (r_job == 2'd3) begin
                            r_state <= S_SETUP;
                        end else begin
                            r_job   <= r_job + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_SETUP: begin
                    if (or_lo_f > or_hi_f || oc_lo_f > oc_hi_f) begin
                        r_state <= S_ADV;
                    end else begin
                        r_orow  <= RB'(or_lo_f);
                        r_or_hi <= RB'(or_hi_f);
                        r_ocol  <= CB'(oc_lo_f);
                        r_oc_lo <= CB'(oc_lo_f);
                        r_oc_hi <= CB'(oc_hi_f);
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    if (skip) begin
                        if (last_win) begin
                            r_state <= S_ADV;
                        end else begin
                            r_orow <= n_orow;
                            r_ocol <= n_ocol;
                        end
                    end else begin
                        r_first <= first;
                        r_emit  <= emit;
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_acc <= acc_new;
                    if (r_emit) begin
                        r_state <= S_AVG_GO;
                    end else if (last_win) begin
                        r_state <= S_ADV;
                    end else begin
                        r_orow  <= n_orow;
                        r_ocol  <= n_ocol;
                        r_state <= S_WIN;
                    end
                end
                S_AVG_GO: r_state <= S_AVG_WAIT;
                S_AVG_WAIT: begin
                    if (avg_done) begin
                        r_avg   <= avg_sat;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= r_avg;
                        r_out_row   <= r_orow;
                        r_out_col   <= r_ocol;
                        r_out_last  <= (DB'(r_orow) == oh_m1) && (DB'(r_ocol) == ow_m1);
                        if (last_win) begin
                            r_state <= S_ADV;
                        end else begin
                            r_orow  <= n_orow;
                            r_ocol  <= n_ocol;
                            r_state <= S_WIN;
                        end
                    end
                end
                S_ADV: begin
                    if (DB'(r_col) + 1'b1 >= cfg.w) begin
                        r_col <= '0;
                        r_row <= (DB'(r_row) + 1'b1 >= cfg.h) ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_average    = $signed(r_out_avg);
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_frame_done = r_out_last;

    // a write-back always follows its own read
    `APOOL_ASSERT(a_wr_after_rd, ram_we |-> $past(ram_re))
    // only one sample in flight
    `APOOL_ASSERT(a_one_item, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // the averaging result lands only where it is awaited
    `APOOL_ASSERT(a_avg_done_state, avg_done |-> (r_state == S_AVG_WAIT))
    // reset leaves the sequencer idle with nothing to deliver
    `APOOL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_out_valid))
endmodule
`default_nettype wire
